@@ rtl/hvd_pkg.sv @@
// Shared types, constants and helpers of the HMM Viterbi decoder.
// Used by hvd_front, hvd_back and the top level; depends on nothing else.
package hvd_pkg;

    localparam int NUM_STATES  = 16;
    localparam int MAX_STEPS   = 1024;
    localparam int ST_W        = $clog2(NUM_STATES);
    localparam int POS_W       = $clog2(MAX_STEPS);
    localparam int STEP_W      = POS_W + 1;
    localparam int SCORE_W     = 32;
    localparam int ACC_W       = 40;
    localparam int ACT_W       = 5;
    localparam int BP_DEPTH    = MAX_STEPS * NUM_STATES;
    localparam int BP_AW       = POS_W + ST_W;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        OP_CLEAR   = 3'd0,
        OP_PRIOR   = 3'd1,
        OP_OBSERVE = 3'd2,
        OP_EMIT    = 3'd3,
        OP_TRANS   = 3'd4,
        OP_END     = 3'd5,
        OP_FINISH  = 3'd6,
        OP_TRACE   = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRANS,
        S_END,
        S_FIN,
        S_TRD,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op                        op;
        logic [ST_W-1:0]            state_index;
        logic [ST_W-1:0]            from_state;
        logic [ST_W-1:0]            symbol;
        logic signed [SCORE_W-1:0]  score;
    } t_item;

    typedef struct packed {
        logic [ST_W-1:0]            path_state;
        logic [POS_W-1:0]           position;
        logic signed [ACC_W-1:0]    path_score;
        logic                       last_flag;
        logic                       error_flag;
    } t_result;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage

@@ rtl/hvd_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module hvd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/hvd_front.sv @@
// Front end: decodes request words and queues them for the execution unit.
// Depends on hvd_pkg.
module hvd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [2:0]                   i_req_type,
    input  logic [hvd_pkg::ST_W-1:0]     i_state_index,
    input  logic [hvd_pkg::ST_W-1:0]     i_from_state,
    input  logic [hvd_pkg::ST_W-1:0]     i_symbol,
    input  logic signed [hvd_pkg::SCORE_W-1:0] i_score,
    output logic                         o_q_valid,
    output hvd_pkg::t_item               o_q_item,
    input  logic                         i_q_pop
);
    import hvd_pkg::*;

    t_item           r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt;
    t_item           w_item;
    logic            w_push, w_pop;

    always_comb begin
        w_item.op          = t_op'(i_req_type);
        w_item.state_index = i_state_index;
        w_item.from_state  = i_from_state;
        w_item.symbol      = i_symbol;
        w_item.score       = i_score;
    end

    assign o_full    = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rd];
    assign w_push    = i_push && !o_full;
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(w_push) - (Q_AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end
endmodule

@@ rtl/hvd_back.sv @@
// Execution unit: trellis state, step walk, best-state search and trace-back.
// Depends on hvd_pkg and hvd_ram.
module hvd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hvd_pkg::ACT_W-1:0]     i_cfg_data,
    input  logic                          i_q_valid,
    input  hvd_pkg::t_item                i_q_item,
    output logic                          o_q_pop,
    output logic                          o_res_valid,
    output hvd_pkg::t_result              o_res,
    input  logic                          i_res_pop
);
    import hvd_pkg::*;

    t_state  r_state, n_state;
    t_item   r_item;
    t_result r_pend;
    t_result r_out;
    logic    r_out_valid;

    logic signed [ACC_W-1:0]   r_path [NUM_STATES];
    logic signed [ACC_W-1:0]   r_cand [NUM_STATES];
    logic [ST_W-1:0]           r_src  [NUM_STATES];
    logic [NUM_STATES-1:0]     r_seen;
    logic signed [SCORE_W-1:0] r_emit [NUM_STATES];
    logic [ST_W-1:0]           r_obs;
    logic [STEP_W-1:0]         r_step;
    logic [POS_W-1:0]          r_tpos;
    logic [ST_W-1:0]           r_tstate;
    logic                      r_ovf;
    logic [ACT_W-1:0]          r_active;
    logic [ACT_W-1:0]          r_j;
    logic [ST_W-1:0]           r_best;
    logic signed [ACC_W-1:0]   r_tcand;

    logic [ACT_W-1:0]          w_na;
    logic [ST_W-1:0]           w_j;
    logic                      w_j_act;
    logic                      w_take;
    logic                      w_out_free;
    logic                      w_bp_we;
    logic [BP_AW-1:0]          w_bp_waddr, w_bp_raddr;
    logic [ST_W-1:0]           w_bp_wdata, w_bp_rdata;
    logic signed [ACC_W-1:0]   w_score_ext;
    logic [POS_W-1:0]          w_last_pos;

    always_comb begin
        if (r_active == '0) begin
            w_na = ACT_W'(1);
        end else if (r_active > ACT_W'(NUM_STATES)) begin
            w_na = ACT_W'(NUM_STATES);
        end else begin
            w_na = r_active;
        end
    end

    assign w_j         = r_j[ST_W-1:0];
    assign w_j_act     = (r_j < w_na);
    assign w_out_free  = !r_out_valid || i_res_pop;
    assign w_score_ext = ACC_W'(i_q_item.score);
    assign w_last_pos  = POS_W'(r_step - STEP_W'(1));

    // Back pointer memory: one row of NUM_STATES entries per position.
    assign w_bp_waddr = {r_step[POS_W-1:0], w_j};
    assign w_bp_wdata = w_j_act ? r_src[w_j] : '0;
    assign w_bp_raddr = {r_tpos, r_tstate};

    hvd_ram #(.WIDTH(ST_W), .DEPTH(BP_DEPTH)) u_bp_ram (
        .i_clk   (i_clk),
        .i_we    (w_bp_we),
        .i_waddr (w_bp_waddr),
        .i_wdata (w_bp_wdata),
        .i_raddr (w_bp_raddr),
        .o_rdata (w_bp_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.op)
                        OP_TRANS: begin
                            if (r_step != '0 && ACT_W'(i_q_item.state_index) < w_na &&
                                ACT_W'(i_q_item.from_state) < w_na) begin
                                n_state = S_TRANS;
                            end
                        end
                        OP_END: begin
                            if (r_step < STEP_W'(MAX_STEPS)) begin
                                n_state = S_END;
                            end
                        end
                        OP_FINISH: begin
                            n_state = (r_step == '0 || r_ovf) ? S_OUT : S_FIN;
                        end
                        OP_TRACE: begin
                            n_state = (r_tpos == '0) ? S_OUT : S_TRD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_TRANS: n_state = S_IDLE;
            S_END:   n_state = (w_j == ST_W'(NUM_STATES - 1)) ? S_IDLE : S_END;
            S_FIN:   n_state = (r_j == ACT_W'(NUM_STATES)) ? S_OUT : S_FIN;
            S_TRD:   n_state = S_OUT;
            S_OUT:   n_state = w_out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        w_take  = 1'b0;
        w_bp_we = 1'b0;
        case (r_state)
            S_IDLE:  w_take  = i_q_valid;
            S_END:   w_bp_we = (r_step != '0);
            default: begin
                w_take  = 1'b0;
                w_bp_we = 1'b0;
            end
        endcase
    end

    assign o_q_pop     = w_take;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= ACT_W'(NUM_STATES);
            r_seen      <= '0;
            r_obs       <= '0;
            r_step      <= '0;
            r_tpos      <= '0;
            r_tstate    <= '0;
            r_ovf       <= 1'b0;
            r_j         <= '0;
            r_best      <= '0;
            for (int k = 0; k < NUM_STATES; k++) begin
                r_path[k] <= '0;
                r_cand[k] <= '0;
                r_src[k]  <= '0;
                r_emit[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            // In S_OUT the output register is handled below.
            if (r_state != S_OUT && r_out_valid && i_res_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_item <= i_q_item;
                        case (i_q_item.op)
                            OP_CLEAR: begin
                                r_seen   <= '0;
                                r_obs    <= '0;
                                r_step   <= '0;
                                r_tpos   <= '0;
                                r_tstate <= '0;
                                r_ovf    <= 1'b0;
                                for (int k = 0; k < NUM_STATES; k++) begin
                                    r_path[k] <= '0;
                                    r_cand[k] <= '0;
                                    r_src[k]  <= '0;
                                    r_emit[k] <= '0;
                                end
                            end
                            OP_PRIOR: begin
                                if (r_step == '0) begin
                                    r_path[i_q_item.state_index] <= w_score_ext;
                                end
                            end
                            OP_OBSERVE: r_obs <= i_q_item.symbol;
                            OP_EMIT: begin
                                if (i_q_item.symbol == r_obs) begin
                                    r_emit[i_q_item.state_index] <= i_q_item.score;
                                end
                            end
                            OP_TRANS: begin
                                r_tcand <= sat_add(r_path[i_q_item.from_state], w_score_ext);
                            end
                            OP_END: begin
                                if (r_step >= STEP_W'(MAX_STEPS)) begin
                                    r_ovf <= 1'b1;
                                end
                                r_j <= '0;
                            end
                            OP_FINISH: begin
                                r_j    <= ACT_W'(1);
                                r_best <= '0;
                                r_pend <= '{path_state: '0, position: '0, path_score: '0,
                                            last_flag: 1'b0, error_flag: 1'b1};
                            end
                            OP_TRACE: begin
                                r_pend <= '{path_state: '0, position: '0, path_score: '0,
                                            last_flag: 1'b0, error_flag: 1'b1};
                            end
                            default: r_j <= r_j;
                        endcase
                    end
                end
                S_TRANS: begin
                    // First candidate wins; later ones on a higher score, or a tie
                    // from a lower source.
                    if (!r_seen[r_item.state_index] ||
                        r_tcand > r_cand[r_item.state_index] ||
                        (r_tcand == r_cand[r_item.state_index] &&
                         r_item.from_state < r_src[r_item.state_index])) begin
                        r_cand[r_item.state_index] <= r_tcand;
                        r_src[r_item.state_index]  <= r_item.from_state;
                        r_seen[r_item.state_index] <= 1'b1;
                    end
                end
                S_END: begin
                    if (w_j_act) begin
                        if (r_step == '0) begin
                            r_path[w_j] <= sat_add(r_path[w_j], ACC_W'(r_emit[w_j]));
                        end else begin
                            r_path[w_j] <= sat_add(r_cand[w_j], ACC_W'(r_emit[w_j]));
                        end
                    end
                    r_j <= r_j + 1'b1;
                    if (w_j == ST_W'(NUM_STATES - 1)) begin
                        r_seen <= '0;
                        r_step <= r_step + 1'b1;
                        for (int k = 0; k < NUM_STATES; k++) begin
                            r_cand[k] <= '0;
                            r_src[k]  <= '0;
                            r_emit[k] <= '0;
                        end
                    end
                end
                S_FIN: begin
                    if (r_j == ACT_W'(NUM_STATES)) begin
                        r_tpos   <= w_last_pos;
                        r_tstate <= r_best;
                        r_pend   <= '{path_state: r_best, position: w_last_pos,
                                      path_score: r_path[r_best],
                                      last_flag: (w_last_pos == '0), error_flag: 1'b0};
                    end else begin
                        if (w_j_act && r_path[w_j] > r_path[r_best]) begin
                            r_best <= w_j;
                        end
                        r_j <= r_j + 1'b1;
                    end
                end
                S_TRD: begin
                    r_tpos   <= r_tpos - 1'b1;
                    r_tstate <= w_bp_rdata;
                    r_pend   <= '{path_state: w_bp_rdata, position: r_tpos - 1'b1,
                                  path_score: '0,
                                  last_flag: (r_tpos == POS_W'(1)), error_flag: 1'b0};
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_j <= r_j;
            endcase
        end
    end

    // The step counter never passes the trellis length.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_W'(MAX_STEPS))
        else $error("step count beyond trellis length");

    // A back pointer read is issued only from idle, for a trace word.
    a_trd_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TRD |-> $past(r_state) == S_IDLE && r_item.op == OP_TRACE)
        else $error("trace read without a trace word");

    // A result is never overwritten while it waits.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_res_pop |=> r_out_valid && $stable(r_out))
        else $error("pending result lost");
endmodule

@@ rtl/hmm_viterbi_decoder_top.sv @@
// Top level of the log-domain HMM Viterbi decoder.
// Depends on hvd_pkg, hvd_front, hvd_back and hvd_ram.
//
// Usage: request words enter through a queue port (push / full); a word
// is taken on a clock edge with push high and full low. Results leave
// through a queue port (empty / pop); the oldest result sits on the o_
// ports while empty is low and is taken on an edge with pop high.
// Only finish and trace words produce a result. active_states is written
// through i_cfg_we / i_cfg_data, by the user only while the block is idle;
// the block itself does not enforce this. A four-word input queue lets the
// host keep pushing while the execution unit works or while a result waits
// to be popped. Clear, prior, observe, emission, an ignored transition and
// an end step past the last position are done from idle; a transition sums,
// then compares; an end step walks the 16 states and writes one back pointer
// per cycle into the back pointer RAM (none on the first step); finish
// compares one state per cycle; trace reads the back pointer RAM. A finish
// or trace that reports an error skips the search or the read. A finish or
// trace ends by loading its result into the output register, which drives
// the ports. One word is worked at a time. Reset clears the control and
// trellis state and sets active_states to 16; the back pointer RAM is not
// cleared. When the receiver stalls, the execution unit holds its next
// result and stops, and the input queue fills and raises full.
module hmm_viterbi_decoder_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [2:0]                          i_req_type,
    input  logic [hvd_pkg::ST_W-1:0]            i_state_index,
    input  logic [hvd_pkg::ST_W-1:0]            i_from_state,
    input  logic [hvd_pkg::ST_W-1:0]            i_symbol,
    input  logic signed [hvd_pkg::SCORE_W-1:0]  i_score,
    output logic                                empty,
    input  logic                                pop,
    output logic [hvd_pkg::ST_W-1:0]            o_path_state,
    output logic [hvd_pkg::POS_W-1:0]           o_position,
    output logic signed [hvd_pkg::ACC_W-1:0]    o_path_score,
    output logic                                o_last_flag,
    output logic                                o_error_flag,
    input  logic                                i_cfg_we,
    input  logic [hvd_pkg::ACT_W-1:0]           i_cfg_data
);
    import hvd_pkg::*;

    logic    w_q_valid, w_q_pop, w_res_valid;
    t_item   w_q_item;
    t_result w_res;

    hvd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_req_type    (i_req_type),
        .i_state_index (i_state_index),
        .i_from_state  (i_from_state),
        .i_symbol      (i_symbol),
        .i_score       (i_score),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    hvd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_pop   (pop)
    );

    assign empty        = !w_res_valid;
    assign o_path_state = w_res.path_state;
    assign o_position   = w_res.position;
    assign o_path_score = w_res.path_score;
    assign o_last_flag  = w_res.last_flag;
    assign o_error_flag = w_res.error_flag;
endmodule
